// ===== rtl/core/lcs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared types for the linear congruence solver: commands and status
// ----------------------------------------------------------------------------
package lcs_pkg;

   // datapath operations issued by the controller
   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_DIV_START,
      OP_DIV_STEP,
      OP_EUCLID_UPD,
      OP_MUL_STEP
   } op_type;

   // division operand selection
   typedef enum logic [1:0] {
      DSEL_EUCLID,
      DSEL_C_BY_D,
      DSEL_B_BY_D,
      DSEL_COEF
   } dsel_type;

   typedef struct packed {
      op_type   op;
      dsel_type dsel;
   } cmd_type;

   typedef struct packed {
      logic rem_zero;
      logic div_done;
      logic mul_done;
      logic d_zero;
      logic m_zero;
   } status_type;

endpackage
`default_nettype wire

// ===== rtl/core/lcs_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcs_datapath
// Euclid registers, shared radix-2 divider and a shift-and-add modular
// multiplier, driven step by step from the controller
// ----------------------------------------------------------------------------
module lcs_datapath #(
   parameter int WORD_BITS = 32
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire lcs_pkg::cmd_type  cmd,
   output lcs_pkg::status_type    status,
   input  wire [WORD_BITS-1:0]    load_a,
   input  wire [WORD_BITS-1:0]    load_b,
   input  wire [WORD_BITS-1:0]    load_c,
   output logic                   res_solvable,
   output logic [WORD_BITS-1:0]   res_solution
);
   import lcs_pkg::*;

   localparam int W  = WORD_BITS;
   localparam int CW = WORD_BITS + 2;
   localparam int NB = $clog2(WORD_BITS + 1);

   logic [W-1:0]  r0_ff, r0_in, r1_ff, r1_in;
   logic [CW-1:0] s0_ff, s0_in, s1_ff, s1_in;
   logic [W-1:0]  b_ff, c_ff, d_ff, m_ff, k_ff;
   logic [W-1:0]  b_in, c_in, d_in, m_in, k_in;
   logic          neg_ff, neg_in;
   // divider
   logic [W-1:0]  dq_ff, dq_in, dr_ff, dr_in, dn_ff, dn_in, dd_ff, dd_in;
   logic [NB-1:0] dcnt_ff, dcnt_in;
   // multiplier
   logic [W:0]    mp_ff, mp_in, macc_ff, macc_in;
   logic [W-1:0]  mq_ff, mq_in;
   logic [W-1:0]  sol_ff, sol_in;
   logic          ok_ff, ok_in;

   logic [W:0]    trial;
   logic [W-1:0]  dnum, dden;
   logic [CW-1:0] qs, coef_abs;
   logic [W:0]    acc_sum, p_dbl;

   // divider operand select, trial subtraction, Euclid quotient product and multiplier sums
   always_comb begin
      coef_abs = s0_ff[CW-1] ? (~s0_ff + CW'(1)) : s0_ff;
      case (cmd.dsel)
         DSEL_EUCLID: begin dnum = r0_ff; dden = r1_ff; end
         DSEL_C_BY_D: begin dnum = c_ff;  dden = r0_ff; end
         DSEL_B_BY_D: begin dnum = b_ff;  dden = d_ff;  end
         DSEL_COEF:   begin dnum = coef_abs[W-1:0]; dden = m_ff; end
         default:     begin dnum = r0_ff; dden = r1_ff; end
      endcase
      trial = {dr_ff, dn_ff[W-1]} - {1'b0, dd_ff};
      qs    = CW'(dq_ff) * s1_ff;
      acc_sum = macc_ff + mp_ff;
      p_dbl   = {mp_ff[W-1:0], 1'b0};
   end

   // next-state for all datapath registers
   always_comb begin
      r0_in = r0_ff; r1_in = r1_ff; s0_in = s0_ff; s1_in = s1_ff;
      b_in = b_ff; c_in = c_ff; d_in = d_ff; m_in = m_ff; k_in = k_ff;
      neg_in = neg_ff;
      dq_in = dq_ff; dr_in = dr_ff; dn_in = dn_ff; dd_in = dd_ff; dcnt_in = dcnt_ff;
      mp_in = mp_ff; macc_in = macc_ff; mq_in = mq_ff;
      sol_in = sol_ff; ok_in = ok_ff;
      case (cmd.op)
         OP_LOAD: begin
            r0_in = load_a; r1_in = load_b; b_in = load_b; c_in = load_c;
            s0_in = CW'(1); s1_in = '0;
         end
         OP_DIV_START: begin
            dq_in = '0; dr_in = '0; dn_in = dnum; dd_in = dden;
            dcnt_in = NB'(W);
            if (cmd.dsel == DSEL_C_BY_D) d_in = r0_ff;
            if (cmd.dsel == DSEL_COEF) neg_in = s0_ff[CW-1];
         end
         OP_DIV_STEP: begin
            dn_in = {dn_ff[W-2:0], 1'b0};
            if (!trial[W]) begin
               dr_in = trial[W-1:0]; dq_in = {dq_ff[W-2:0], 1'b1};
            end else begin
               dr_in = {dr_ff[W-2:0], dn_ff[W-1]}; dq_in = {dq_ff[W-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff - NB'(1);
            // results land as each division finishes
            if (dcnt_ff == NB'(1)) begin
               case (cmd.dsel)
                  DSEL_C_BY_D: begin
                     ok_in = (dr_in == '0); k_in = dq_in;
                  end
                  DSEL_B_BY_D: begin
                     m_in = dq_in;
                     // with a zero modulus the solution is c/d as it stands
                     sol_in = k_ff;
                  end
                  DSEL_COEF: begin
                     mp_in   = {1'b0, (neg_ff && dr_in != '0) ? m_ff - dr_in : dr_in};
                     macc_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         OP_EUCLID_UPD: begin
            r0_in = r1_ff; r1_in = dr_ff;
            s0_in = s1_ff; s1_in = s0_ff - qs;
         end
         OP_MUL_STEP: begin
            if (mq_ff[0]) macc_in = (acc_sum >= {1'b0, m_ff}) ? acc_sum - {1'b0, m_ff}
                                                                : acc_sum;
            mp_in = (p_dbl >= {1'b0, m_ff}) ? p_dbl - {1'b0, m_ff} : p_dbl;
            mq_in = mq_ff >> 1;
            sol_in = macc_in[W-1:0];
         end
         default: ;
      endcase
      // multiplier operand c/d, reduced mod m on the fly by the shift-and-add loop
      if (cmd.op == OP_DIV_STEP && cmd.dsel == DSEL_COEF && dcnt_ff == NB'(1))
         mq_in = k_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r0_ff <= '0; r1_ff <= '0; s0_ff <= '0; s1_ff <= '0; d_ff <= '0;
         dcnt_ff <= '0;
      end else begin
         r0_ff <= r0_in; r1_ff <= r1_in; s0_ff <= s0_in; s1_ff <= s1_in;
         d_ff <= d_in; dcnt_ff <= dcnt_in;
      end
      b_ff <= b_in; c_ff <= c_in; m_ff <= m_in; k_ff <= k_in; neg_ff <= neg_in;
      dq_ff <= dq_in; dr_ff <= dr_in; dn_ff <= dn_in; dd_ff <= dd_in;
      mp_ff <= mp_in; macc_ff <= macc_in; mq_ff <= mq_in;
      sol_ff <= sol_in; ok_ff <= ok_in;
   end

   assign status.rem_zero = (r1_ff == '0);
   assign status.div_done = (dcnt_ff == NB'(1));
   assign status.mul_done = (mq_ff == '0);
   assign status.d_zero   = (r0_ff == '0);
   assign status.m_zero   = (m_ff == '0);
   assign res_solvable    = ok_ff;
   assign res_solution    = sol_ff;
endmodule
`default_nettype wire

// ===== rtl/core/lcs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcs_ctrl
// Sequencer: euclid loop, divisibility test, reduction and modular multiply
// ----------------------------------------------------------------------------
module lcs_ctrl (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   input  wire                       rhs_zero,
   input  wire                       ok,
   output lcs_pkg::cmd_type          cmd,
   output logic                      force_sol_zero,
   output logic                      force_ok,
   input  wire lcs_pkg::status_type  status
);
   import lcs_pkg::*;

   typedef enum logic [10:0] {
      S_IDLE  = 11'b00000000001,
      S_CHECK = 11'b00000000010,
      S_EDIV  = 11'b00000000100,
      S_EUPD  = 11'b00000001000,
      S_CDIV  = 11'b00000010000,
      S_BDIV  = 11'b00000100000,
      S_XDIV  = 11'b00001000000,
      S_KDIV  = 11'b00010000000,
      S_MUL   = 11'b00100000000,
      S_DONE  = 11'b01000000000,
      S_FIN   = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   logic      run_ff, run_in;   // divider busy inside a division state
   logic      zsol_ff, zsol_in, zok_ff, zok_in, zmode_ff, zmode_in, pend_ff, pend_in;

   always_comb begin
      state_in = state_ff; run_in = run_ff;
      zsol_in = zsol_ff; zok_in = zok_ff; zmode_in = zmode_ff; pend_in = pend_ff;
      cmd.op = OP_NONE; cmd.dsel = DSEL_EUCLID;
      case (state_ff)
         S_IDLE: if (req_valid) begin
            cmd.op = OP_LOAD; state_in = S_CHECK; zmode_in = 1'b0; zsol_in = 1'b0;
         end
         S_CHECK: begin
            if (status.rem_zero) begin
               if (status.d_zero) begin
                  zmode_in = 1'b1; zok_in = rhs_zero; state_in = S_DONE;
               end else begin
                  state_in = S_CDIV; run_in = 1'b0;
               end
            end else begin
               state_in = S_EDIV; run_in = 1'b0;
            end
         end
         S_EDIV: begin
            cmd.dsel = DSEL_EUCLID;
            if (!run_ff) begin cmd.op = OP_DIV_START; run_in = 1'b1; end
            else begin
               cmd.op = OP_DIV_STEP;
               if (status.div_done) begin run_in = 1'b0; state_in = S_EUPD; end
            end
         end
         S_EUPD: begin cmd.op = OP_EUCLID_UPD; state_in = S_CHECK; end
         S_CDIV: begin
            cmd.dsel = DSEL_C_BY_D;
            if (!run_ff) begin cmd.op = OP_DIV_START; run_in = 1'b1; end
            else begin
               cmd.op = OP_DIV_STEP;
               if (status.div_done) begin run_in = 1'b0; state_in = S_BDIV; end
            end
         end
         S_BDIV: begin
            cmd.dsel = DSEL_B_BY_D;
            if (!ok) begin zsol_in = 1'b1; state_in = S_DONE; end
            else if (!run_ff) begin cmd.op = OP_DIV_START; run_in = 1'b1; end
            else begin
               cmd.op = OP_DIV_STEP;
               if (status.div_done) begin run_in = 1'b0; state_in = S_XDIV; end
            end
         end
         S_XDIV: begin
            // zero modulus: solution is c/d already held
            if (status.m_zero) state_in = S_DONE;
            else begin
               cmd.dsel = DSEL_COEF;
               if (!run_ff) begin cmd.op = OP_DIV_START; run_in = 1'b1; end
               else begin
                  cmd.op = OP_DIV_STEP;
                  if (status.div_done) begin run_in = 1'b0; state_in = S_KDIV; end
               end
            end
         end
         S_KDIV: state_in = S_MUL;
         S_MUL: begin
            if (status.mul_done) state_in = S_DONE;
            else cmd.op = OP_MUL_STEP;
         end
         S_DONE: begin pend_in = 1'b1; state_in = S_FIN; end
         S_FIN: if (!rsp_stall) begin pend_in = 1'b0; state_in = S_IDLE; end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; run_ff <= 1'b0; pend_ff <= 1'b0;
         zsol_ff <= 1'b0; zok_ff <= 1'b0; zmode_ff <= 1'b0;
      end else begin
         state_ff <= state_in; run_ff <= run_in; pend_ff <= pend_in;
         zsol_ff <= zsol_in; zok_ff <= zok_in; zmode_ff <= zmode_in;
      end
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = pend_ff;
   assign force_sol_zero = zsol_ff | zmode_ff;
   assign force_ok       = zmode_ff ? zok_ff : ok;
endmodule
`default_nettype wire

// ===== rtl/core/linear_congruence_solver.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// linear_congruence_solver
// Solves a*x = c (mod b) by extended Euclid and a modular multiply
// ----------------------------------------------------------------------------
//   channel  ports                           role
//   req      req_valid/req_stall, a, b, c    request in
//   rsp      rsp_valid/rsp_stall, flags      result out
// One request at a time. Each Euclid step uses the shared radix-2 divider;
// then up to three further divisions and up to WORD_BITS multiply steps.
// Synchronous reset returns the sequencer to idle. A stalled result holds.
module linear_congruence_solver #(
   parameter int WORD_BITS = 32
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire [31:0]  req_coeff_a,
   input  wire [31:0]  req_modulus_b,
   input  wire [31:0]  req_rhs_c,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic        rsp_solvable,
   output logic [31:0] rsp_solution
);
   import lcs_pkg::*;

   cmd_type          cmd;
   status_type       status;
   logic             ok, fz, fok;
   logic [WORD_BITS-1:0] sol;
   logic             c_zero_ff;

   // remember whether c was zero for the double zero case
   always_ff @(posedge clock)
      if (req_valid && !req_stall) c_zero_ff <= (WORD_BITS'(req_rhs_c) == '0);

   lcs_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .rhs_zero(c_zero_ff), .ok, .cmd, .force_sol_zero(fz), .force_ok(fok), .status
   );

   lcs_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
      .clock, .reset, .cmd, .status,
      .load_a(WORD_BITS'(req_coeff_a)), .load_b(WORD_BITS'(req_modulus_b)),
      .load_c(WORD_BITS'(req_rhs_c)), .res_solvable(ok), .res_solution(sol)
   );

   assign rsp_solvable = fok;
   assign rsp_solution = fz ? 32'd0 : 32'(sol);
endmodule
`default_nettype wire
